// ===== rtl/core/ljpe_pkg.sv =====
// ljpe_pkg: widths, register indexes, pipeline payload types and helpers
// for the lennard-jones pair energy unit. no dependencies.
package ljpe_pkg;

  localparam int POS_W  = 24;   // signed Q8.16 coordinate
  localparam int DIFF_W = 25;   // coordinate difference
  localparam int MAG_W  = 24;   // magnitude of a difference
  localparam int SQ_W   = 48;   // square of a magnitude
  localparam int R2_W   = 50;   // sum of three squares
  localparam int REG_W  = 20;   // Q4.16 epsilon or sigma
  localparam int EPS4_W = 22;   // 4 * epsilon
  localparam int S2_W   = 40;   // sigma squared
  localparam int FRAC   = 16;
  localparam int Q_W    = 21;   // (sigma/r)^2 below 32.0 in Q.16
  localparam int Q2_W   = 26;
  localparam int Q3_W   = 31;
  localparam int Q6_W   = 46;
  localparam int DQ_W   = 47;   // signed q6 - q3
  localparam int HI_W   = DQ_W - FRAC;
  localparam int PH_W   = EPS4_W + HI_W;      // signed high partial product
  localparam int PL_W   = EPS4_W + FRAC;      // low partial product
  localparam int E_W    = PH_W + 1;           // energy before clipping
  localparam int OUT_W  = 32;
  localparam int REM_W  = R2_W + 1;           // divider partial remainder
  localparam int OVF_SH = 5;                  // q >= 32.0 test shift
  localparam int NPAIRS = 3;
  localparam int CFG_IDX_W = 3;

  localparam logic [OUT_W-1:0] E_MAX   = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [REG_W-1:0] REG_ONE = REG_W'(1 << FRAC);

  localparam logic [CFG_IDX_W-1:0] REG_EPS_AA = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EPS_AB = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EPS_BB = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIG_AA = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIG_AB = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SIG_BB = 3'd5;

  typedef logic [1:0] pair_idx_t;

  // flags and scale that ride alongside the divider and power stages
  typedef struct packed {
    logic              r2_zero;
    logic              ovf;
    logic              eps_zero;
    logic [EPS4_W-1:0] eps4;
  } side_t;

  typedef struct packed {
    side_t            side;
    logic [R2_W-1:0]  dvs;
    logic [REM_W-1:0] rem;
    logic [Q_W-1:0]   num_lo;
    logic [Q_W-1:0]   quo;
  } div_t;

  // triangular index max*(max+1)/2 + min, which for one-bit types is max + min
  function automatic pair_idx_t pair_index(input logic a, input logic b);
    logic hi;
    logic lo;
    hi = a | b;
    lo = a & b;
    return pair_idx_t'(hi) + pair_idx_t'(lo);
  endfunction

endpackage

// ===== rtl/core/lennard_jones_pair_energy_unit.sv =====
// Lennard-Jones 12-6 pair energy unit: one atom pair per cycle in, one energy
// per cycle out when not stalled. At its centre is the 21-stage divider that
// forms (sigma/r)^2, one quotient bit a stage, with four distance stages
// before it and six power and scaling stages after. The whole pipeline moves
// together; it holds only while a finished result waits on out_stall. Energy
// is signed Q16.16, clipped to the largest positive value with out_saturated
// set on overflow or coincident positions.
// Depends on ljpe_pkg, ljpe_dist, ljpe_div, ljpe_poly.
module lennard_jones_pair_energy_unit import ljpe_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_first_material,
  input  logic                    in_second_material,
  input  logic signed [POS_W-1:0] in_first_x,
  input  logic signed [POS_W-1:0] in_first_y,
  input  logic signed [POS_W-1:0] in_first_z,
  input  logic signed [POS_W-1:0] in_second_x,
  input  logic signed [POS_W-1:0] in_second_y,
  input  logic signed [POS_W-1:0] in_second_z,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] out_pair_energy,
  output logic                    out_saturated,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [REG_W-1:0]        cfg_wdata
);

  logic [REG_W-1:0]        eps_r [NPAIRS];
  logic [REG_W-1:0]        sig_r [NPAIRS];
  logic                    adv;
  pair_idx_t               pidx;
  logic signed [POS_W-1:0] p1 [3];
  logic signed [POS_W-1:0] p2 [3];
  logic                    dist_vld, div_vld;
  div_t                    dist_dat;
  logic [Q_W-1:0]          div_q;
  side_t                   div_side;
  logic [OUT_W-1:0]        energy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NPAIRS; i++) begin
        eps_r[i] <= REG_ONE;
        sig_r[i] <= REG_ONE;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        REG_EPS_AA: eps_r[0] <= cfg_wdata;
        REG_EPS_AB: eps_r[1] <= cfg_wdata;
        REG_EPS_BB: eps_r[2] <= cfg_wdata;
        REG_SIG_AA: sig_r[0] <= cfg_wdata;
        REG_SIG_AB: sig_r[1] <= cfg_wdata;
        REG_SIG_BB: sig_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;
  assign pidx     = pair_index(in_first_material, in_second_material);

  assign p1[0] = in_first_x;
  assign p1[1] = in_first_y;
  assign p1[2] = in_first_z;
  assign p2[0] = in_second_x;
  assign p2[1] = in_second_y;
  assign p2[2] = in_second_z;

  ljpe_dist u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (in_valid),
    .p1      (p1),
    .p2      (p2),
    .eps     (eps_r[pidx]),
    .sig     (sig_r[pidx]),
    .out_vld (dist_vld),
    .out_dat (dist_dat)
  );

  ljpe_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (dist_vld),
    .in_dat   (dist_dat),
    .out_vld  (div_vld),
    .out_q    (div_q),
    .out_side (div_side)
  );

  ljpe_poly u_poly (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_vld     (div_vld),
    .in_q       (div_q),
    .in_side    (div_side),
    .out_vld    (out_valid),
    .out_energy (energy),
    .out_sat    (out_saturated)
  );

  assign out_pair_energy = $signed(energy);

endmodule

// ===== rtl/core/ljpe_dist.sv =====
// ljpe_dist: squared distance, sigma squared and the divider setup,
// four register stages. depends on ljpe_pkg.
module ljpe_dist import ljpe_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    in_vld,
  input  logic signed [POS_W-1:0] p1 [3],
  input  logic signed [POS_W-1:0] p2 [3],
  input  logic [REG_W-1:0]        eps,
  input  logic [REG_W-1:0]        sig,
  output logic                    out_vld,
  output div_t                    out_dat
);

  logic                     va_r, vb_r, vc_r, vd_r;
  logic signed [DIFF_W-1:0] dif_r [3];
  logic [REG_W-1:0]         eps_a_r, sig_a_r, eps_b_r, eps_c_r;
  logic [SQ_W-1:0]          sq_r [3];
  logic [S2_W-1:0]          s2_b_r, s2_c_r;
  logic [R2_W-1:0]          r2_r;
  div_t                     dd_r;
  logic [MAG_W-1:0]         mag [3];
  div_t                     dd_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else if (adv) begin
      va_r <= in_vld;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = dif_r[i][DIFF_W-1] ? MAG_W'(-dif_r[i]) : MAG_W'(dif_r[i]);
    end
  end

  always_comb begin
    dd_nxt.side.r2_zero  = (r2_r == '0);
    // q >= 32.0 exactly when s2 >= 32 * r2
    dd_nxt.side.ovf      = {{(R2_W+OVF_SH-S2_W){1'b0}}, s2_c_r} >= {r2_r, {OVF_SH{1'b0}}};
    dd_nxt.side.eps_zero = (eps_c_r == '0);
    dd_nxt.side.eps4     = {eps_c_r, 2'b00};
    dd_nxt.dvs           = r2_r;
    // dividend is s2 << 16; its top part is s2 >> 5, the lower 21 bits feed in
    dd_nxt.rem           = REM_W'(s2_c_r[S2_W-1:OVF_SH]);
    dd_nxt.num_lo        = {s2_c_r[OVF_SH-1:0], {FRAC{1'b0}}};
    dd_nxt.quo           = '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        dif_r[i] <= $signed({p2[i][POS_W-1], p2[i]}) - $signed({p1[i][POS_W-1], p1[i]});
        sq_r[i]  <= SQ_W'(mag[i]) * SQ_W'(mag[i]);
      end
      eps_a_r <= eps;
      sig_a_r <= sig;
      eps_b_r <= eps_a_r;
      s2_b_r  <= S2_W'(sig_a_r) * S2_W'(sig_a_r);
      eps_c_r <= eps_b_r;
      s2_c_r  <= s2_b_r;
      r2_r    <= R2_W'(sq_r[0]) + R2_W'(sq_r[1]) + R2_W'(sq_r[2]);
      dd_r    <= dd_nxt;
    end
  end

  assign out_vld = vd_r;
  assign out_dat = dd_r;

endmodule

// ===== rtl/core/ljpe_div.sv =====
// ljpe_div: pipelined restoring divider, one quotient bit per stage,
// giving (sigma/r)^2 in Q.16. depends on ljpe_pkg.
module ljpe_div import ljpe_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           in_vld,
  input  div_t           in_dat,
  output logic           out_vld,
  output logic [Q_W-1:0] out_q,
  output side_t          out_side
);

  div_t stg_r  [Q_W];
  div_t stg_in [Q_W];
  logic vld_r  [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic [REM_W-1:0] trial;
    logic             ge;
    div_t             stg_nxt;
    logic             vin;

    if (k == 0) begin : g_first
      assign stg_in[k] = in_dat;
      assign vin       = in_vld;
    end else begin : g_next
      assign stg_in[k] = stg_r[k-1];
      assign vin       = vld_r[k-1];
    end

    always_comb begin
      trial   = {stg_in[k].rem[REM_W-2:0], stg_in[k].num_lo[Q_W-1]};
      ge      = trial >= REM_W'(stg_in[k].dvs);
      stg_nxt = stg_in[k];
      stg_nxt.rem    = ge ? trial - REM_W'(stg_in[k].dvs) : trial;
      stg_nxt.num_lo = {stg_in[k].num_lo[Q_W-2:0], 1'b0};
      stg_nxt.quo    = {stg_in[k].quo[Q_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv) begin
        vld_r[k] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        stg_r[k] <= stg_nxt;
      end
    end
  end

  assign out_vld  = vld_r[Q_W-1];
  assign out_q    = stg_r[Q_W-1].quo;
  assign out_side = stg_r[Q_W-1].side;

endmodule

// ===== rtl/core/ljpe_poly.sv =====
// ljpe_poly: powers q^3 and q^6, the scaled difference and saturation,
// six register stages ending in the output register. depends on ljpe_pkg.
module ljpe_poly import ljpe_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             in_vld,
  input  logic [Q_W-1:0]   in_q,
  input  side_t            in_side,
  output logic             out_vld,
  output logic [OUT_W-1:0] out_energy,
  output logic             out_sat
);

  logic [5:0]              v_r;
  side_t                   sd_r [5];
  logic [Q_W-1:0]          q2q_r;
  logic [Q2_W-1:0]         q2_r;
  logic [Q3_W-1:0]         q3_r, q3b_r;
  logic [Q6_W-1:0]         q6_r;
  logic signed [DQ_W-1:0]  dq_r;
  logic signed [PH_W-1:0]  ph_r;
  logic [PL_W-1:0]         pl_r;
  logic [OUT_W-1:0]        energy_r;
  logic                    sat_r;

  logic [2*Q_W-1:0]        m1;
  logic [Q2_W+Q_W-1:0]     m2;
  logic [2*Q3_W-1:0]       m3;
  logic signed [HI_W-1:0]  hi;
  logic signed [E_W-1:0]   e;
  logic [OUT_W-1:0]        energy_nxt;
  logic                    sat_nxt;

  assign m1 = (2*Q_W)'(in_q) * (2*Q_W)'(in_q);
  assign m2 = (Q2_W+Q_W)'(q2_r) * (Q2_W+Q_W)'(q2q_r);
  assign m3 = (2*Q3_W)'(q3_r) * (2*Q3_W)'(q3_r);
  assign hi = dq_r[DQ_W-1:FRAC];
  // floor(eps4 * dq / 2^16) split into high and low halves of dq
  assign e  = $signed({ph_r[PH_W-1], ph_r})
            + $signed({{(E_W-PL_W+FRAC){1'b0}}, pl_r[PL_W-1:FRAC]});

  always_comb begin
    if (sd_r[4].r2_zero) begin
      energy_nxt = E_MAX;
      sat_nxt    = 1'b1;
    end else if (sd_r[4].ovf) begin
      energy_nxt = sd_r[4].eps_zero ? '0 : E_MAX;
      sat_nxt    = !sd_r[4].eps_zero;
    end else if (!e[E_W-1] && (|e[E_W-2:OUT_W-1])) begin
      energy_nxt = E_MAX;
      sat_nxt    = 1'b1;
    end else begin
      energy_nxt = e[OUT_W-1:0];
      sat_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[4:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd_r[0] <= in_side;
      for (int i = 1; i < 5; i++) begin
        sd_r[i] <= sd_r[i-1];
      end
      q2_r     <= m1[2*Q_W-1:FRAC];
      q2q_r    <= in_q;
      q3_r     <= m2[Q2_W+Q_W-1:FRAC];
      q6_r     <= m3[2*Q3_W-1:FRAC];
      q3b_r    <= q3_r;
      dq_r     <= $signed({1'b0, q6_r}) - $signed({{(DQ_W-Q3_W){1'b0}}, q3b_r});
      ph_r     <= $signed({{(PH_W-EPS4_W){1'b0}}, sd_r[3].eps4})
                * $signed({{(PH_W-HI_W){hi[HI_W-1]}}, hi});
      pl_r     <= PL_W'(sd_r[3].eps4) * PL_W'(dq_r[FRAC-1:0]);
      energy_r <= energy_nxt;
      sat_r    <= sat_nxt;
    end
  end

  assign out_vld    = v_r[5];
  assign out_energy = energy_r;
  assign out_sat    = sat_r;

endmodule
